// ----- rtl/core/pacs_pkg.sv -----
// ----------------------------------------------------------------------------
// pacs_pkg - shared types and constants of the pulse-width angle smoother
// Widths, register codes, reset values and the controller command word.
// ----------------------------------------------------------------------------
`default_nettype none

package pacs_pkg;

	// fraction bits of the angle representation
	localparam int FRAC_BITS = 14;

	localparam int PULSE_W    = 16;
	localparam int GAIN_W     = 15;
	localparam int GAIN_BITS  = 14;
	localparam int GAIN_ONE   = 1 << GAIN_BITS;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_W      = 23;

	// 180 << FRAC_BITS fits in FRAC_BITS + 8 magnitude bits
	localparam int ANG_W     = FRAC_BITS + 9;
	localparam int NUM_W     = PULSE_W + FRAC_BITS;
	localparam int DIV_STEPS = NUM_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	localparam logic [PULSE_W-1:0] MIN_A_RST = PULSE_W'(36);
	localparam logic [PULSE_W-1:0] SPAN_A_RST = PULSE_W'(20138);
	localparam logic [PULSE_W-1:0] MIN_B_RST = PULSE_W'(36);
	localparam logic [PULSE_W-1:0] SPAN_B_RST = PULSE_W'(20500);
	localparam logic [GAIN_W-1:0] GAIN_RST = GAIN_W'(3277);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MIN_A  = 3'd0,
		REG_SPAN_A = 3'd1,
		REG_MIN_B  = 3'd2,
		REG_SPAN_B = 3'd3,
		REG_GAIN   = 3'd4
	} pacs_reg_t;

	typedef struct packed {
		logic load_in;
		logic div_start;
		logic div_step;
		logic angle;
		logic delta;
		logic mul;
		logic acc;
		logic emit;
		logic ch;
	} pacs_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/pacs_if.sv -----
// ----------------------------------------------------------------------------
// pacs_if - word channels of the pulse-width angle smoother
// Input pulse words, output angle words and configuration writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface pacs_in_if import pacs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [PULSE_W-1:0] pulse_a;
	logic [PULSE_W-1:0] pulse_b;

	modport source(output valid, output pulse_a, output pulse_b, input ready);
	modport sink(input valid, input pulse_a, input pulse_b, output ready);
endinterface

interface pacs_out_if import pacs_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic signed [OUT_W-1:0] angle_a;
	logic signed [OUT_W-1:0] angle_b;

	modport source(output valid, output angle_a, output angle_b, input ready);
	modport sink(input valid, input angle_a, input angle_b, output ready);
endinterface

interface pacs_cfg_if import pacs_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/pwm_angle_circular_smoother.sv -----
// An input word is accepted only in idle; channel a then channel b each pass through set-up,
// the shared restoring divider (16 + FRAC_BITS quotient bits, one per cycle), angle
// mapping and the filter; the result then waits until the output register is free.
// A new input word is taken only after the previous result has entered the output register.
// The output register holds a finished word while the next input word is taken.
// Reset (arst_n low) clears both filters and seed flags and loads register defaults.
// ----------------------------------------------------------------------------
// pwm_angle_circular_smoother - two-channel circular angle smoother
// Maps encoder pulse widths to Q angles in [-180,180) and smooths them with
// a circular exponential moving average.
// ----------------------------------------------------------------------------
`default_nettype none

module pwm_angle_circular_smoother import pacs_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	pacs_in_if.sink   in_ch,
	pacs_out_if.source out_ch,
	pacs_cfg_if.sink  cfg_ch
);

	pacs_cmd_t cmd;

	// configuration words are always taken and land at once; send them only while idle
	assign cfg_ch.ready = 1'b1;

	// sequence the datapath through both channels
	pacs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// divider, angle map, filter state and output register
	pacs_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.pulse_a   (in_ch.pulse_a),
		.pulse_b   (in_ch.pulse_b),
		.cfg_we    (cfg_ch.valid),
		.cfg_index (cfg_ch.index),
		.cfg_data  (cfg_ch.data),
		.angle_a   (out_ch.angle_a),
		.angle_b   (out_ch.angle_b)
	);

endmodule

`default_nettype wire

// ----- rtl/core/pacs_ctrl.sv -----
// ----------------------------------------------------------------------------
// pacs_ctrl - sequencer of the pulse-width angle smoother
// Steps the shared datapath through both channels and owns the output flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pacs_ctrl import pacs_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output pacs_cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_DIV,
		S_ANGLE,
		S_DELTA,
		S_MUL,
		S_ACC,
		S_EMIT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] cnt_q;
	logic             ch_q;
	logic             out_valid_q;
	logic             emit;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign emit      = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	always_comb begin
		cmd           = '0;
		cmd.ch        = ch_q;
		cmd.load_in   = in_valid && in_ready;
		cmd.div_start = (state_q == S_START);
		cmd.div_step  = (state_q == S_DIV);
		cmd.angle     = (state_q == S_ANGLE);
		cmd.delta     = (state_q == S_DELTA);
		cmd.mul       = (state_q == S_MUL);
		cmd.acc       = (state_q == S_ACC);
		cmd.emit      = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ch_q        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_START;
						ch_q    <= 1'b0;
					end
				end
				S_START: begin
					cnt_q   <= '0;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (cnt_q == CNT_W'(DIV_STEPS - 1))
						state_q <= S_ANGLE;
					else
						cnt_q <= cnt_q + 1'b1;
				end
				S_ANGLE: state_q <= S_DELTA;
				S_DELTA: state_q <= S_MUL;
				S_MUL:   state_q <= S_ACC;
				S_ACC: begin
					if (!ch_q) begin
						ch_q    <= 1'b1;
						state_q <= S_START;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// the divider never runs past its last quotient bit
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (cnt_q <= CNT_W'(DIV_STEPS - 1)))
		else $error("divider step count overran");

	// an accepted word always starts on channel a
	a_start_a: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == S_START && !ch_q))
		else $error("accepted word did not start channel a");

	// channel b finishing leads straight to the output stage
	a_b_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_ACC && ch_q) |=> (state_q == S_EMIT))
		else $error("channel b did not hand over to output");

	// a pending result is never overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !emit)
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// ----- rtl/core/pacs_dp.sv -----
// ----------------------------------------------------------------------------
// pacs_dp - datapath of the pulse-width angle smoother
// Configuration registers, shared restoring divider, angle map and filter.
// ----------------------------------------------------------------------------
`default_nettype none

module pacs_dp import pacs_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire pacs_cmd_t             cmd,
	input  wire logic [PULSE_W-1:0]    pulse_a,
	input  wire logic [PULSE_W-1:0]    pulse_b,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output logic signed [OUT_W-1:0]    angle_a,
	output logic signed [OUT_W-1:0]    angle_b
);

	localparam int PROD_W = GAIN_W + 1 + ANG_W;
	localparam logic signed [ANG_W:0] HALF = (ANG_W + 1)'(180 << FRAC_BITS);
	localparam logic signed [ANG_W:0] FULL = (ANG_W + 1)'(360 << FRAC_BITS);

	// one modulo-360 reduction for values within one turn of the range
	function automatic logic signed [ANG_W-1:0] wrap1(input logic signed [ANG_W:0] x);
		logic signed [ANG_W:0] r;
		r = x;
		if (x >= HALF)
			r = x - FULL;
		else if (x < -HALF)
			r = x + FULL;
		return r[ANG_W-1:0];
	endfunction

	logic [PULSE_W-1:0] min_a_q, span_a_q, min_b_q, span_b_q;
	logic [GAIN_W-1:0]  gain_q;
	logic [PULSE_W-1:0] pulse_a_q, pulse_b_q;

	logic               sign_q;
	logic [PULSE_W-1:0] rem_q;
	logic [PULSE_W-1:0] dvs_q;
	logic [NUM_W-1:0]   quo_q;

	logic signed [ANG_W-1:0]  now_q;
	logic signed [ANG_W-1:0]  delta_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [ANG_W-1:0]  filt_q [2];
	logic [1:0]               seeded_q;
	logic signed [OUT_W-1:0]  angle_a_q, angle_b_q;

	// start of a channel
	logic [PULSE_W-1:0] sel_pulse, sel_min, sel_span;
	logic [PULSE_W:0]   diff, mag;
	// divider step
	logic [PULSE_W:0]   trial;
	logic               ge;
	// angle map
	logic [FRAC_BITS-1:0] q_lo, r_lo, u_lo;
	logic [ANG_W-1:0]     scaled;
	logic signed [ANG_W:0] now_full;
	// filter
	logic signed [ANG_W-1:0]  prev;
	logic signed [ANG_W:0]    d_full;
	logic [GAIN_W-1:0]        g_sat;
	logic signed [PROD_W-1:0] step;
	logic signed [ANG_W:0]    sum;

	always_comb begin
		sel_pulse = cmd.ch ? pulse_b_q : pulse_a_q;
		sel_min   = cmd.ch ? min_b_q : min_a_q;
		sel_span  = cmd.ch ? span_b_q : span_a_q;
		diff      = {1'b0, sel_pulse} - {1'b0, sel_min};
		mag       = diff[PULSE_W] ? -diff : diff;

		trial = {rem_q, quo_q[NUM_W-1]};
		ge    = (trial >= {1'b0, dvs_q});

		// 360*ratio mod 360 turns depends only on the low fraction bits
		q_lo     = quo_q[FRAC_BITS-1:0];
		r_lo     = sign_q ? -q_lo : q_lo;
		u_lo     = r_lo + FRAC_BITS'(1 << (FRAC_BITS - 1));
		scaled   = ANG_W'(u_lo) * ANG_W'(360);
		now_full = $signed({1'b0, scaled}) - HALF;

		prev   = filt_q[cmd.ch];
		d_full = {now_q[ANG_W-1], now_q} - {prev[ANG_W-1], prev};
		g_sat  = (gain_q > GAIN_W'(GAIN_ONE)) ? GAIN_W'(GAIN_ONE) : gain_q;
		step   = prod_q >>> GAIN_BITS;
		sum    = {prev[ANG_W-1], prev} + step[ANG_W:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_a_q  <= MIN_A_RST;
			span_a_q <= SPAN_A_RST;
			min_b_q  <= MIN_B_RST;
			span_b_q <= SPAN_B_RST;
			gain_q   <= GAIN_RST;
			filt_q[0] <= '0;
			filt_q[1] <= '0;
			seeded_q <= '0;
		end else begin
			if (cfg_we) begin
				case (pacs_reg_t'(cfg_index))
					REG_MIN_A:  min_a_q  <= cfg_data;
					REG_SPAN_A: span_a_q <= cfg_data;
					REG_MIN_B:  min_b_q  <= cfg_data;
					REG_SPAN_B: span_b_q <= cfg_data;
					REG_GAIN:   gain_q   <= cfg_data[GAIN_W-1:0];
					default: ;
				endcase
			end
			if (cmd.acc) begin
				filt_q[cmd.ch]   <= seeded_q[cmd.ch] ? wrap1(sum) : now_q;
				seeded_q[cmd.ch] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pulse_a_q <= pulse_a;
			pulse_b_q <= pulse_b;
		end
		if (cmd.div_start) begin
			sign_q <= diff[PULSE_W];
			rem_q  <= '0;
			quo_q  <= {mag[PULSE_W-1:0], {FRAC_BITS{1'b0}}};
			// zero span acts as one
			dvs_q  <= (sel_span == '0) ? PULSE_W'(1) : sel_span;
		end
		if (cmd.div_step) begin
			rem_q <= ge ? PULSE_W'(trial - {1'b0, dvs_q}) : trial[PULSE_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
		if (cmd.angle)
			now_q <= now_full[ANG_W-1:0];
		if (cmd.delta)
			delta_q <= wrap1(d_full);
		if (cmd.mul)
			prod_q <= $signed(PROD_W'({1'b0, g_sat})) * PROD_W'(delta_q);
		if (cmd.emit) begin
			angle_a_q <= OUT_W'(filt_q[0]);
			angle_b_q <= OUT_W'(filt_q[1]);
		end
	end

	assign angle_a = angle_a_q;
	assign angle_b = angle_b_q;

endmodule

`default_nettype wire
